// ===== sv/rpf_pkg.sv =====
package rpf_pkg;

  localparam int FRAC_BITS = 24;
  localparam int LOG_W     = 29;
  localparam int FR_W      = 32;
  localparam int K_W       = 9;
  localparam int GAMMA_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [1:0] MODE_GRAY      = 2'd0;
  localparam logic [1:0] MODE_MASK      = 2'd1;
  localparam logic [1:0] MODE_THRESHOLD = 2'd2;
  localparam logic [1:0] MODE_GAMMA     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CH_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 2'd2;

  typedef logic [FR_W-1:0] root_tab_t [FRAC_BITS];

  typedef struct packed {
    logic [31:0]      z;
    logic [LOG_W-1:0] acc;
    logic             zero;
  } log_stage_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] f;
    logic [FR_W-1:0]      fr;
    logic [K_W-1:0]       k;
    logic                 zero;
  } exp_stage_t;

  typedef struct packed {
    logic [FR_W-1:0] fr;
    logic [K_W-1:0]  k;
    logic            zero;
  } div_ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t calc_roots();
    root_tab_t   t;
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    t[0] = c[FR_W-1:0];
    for (int i = 1; i < FRAC_BITS; i++) begin
      c = isqrt64(c << 30);
      t[i] = c[FR_W-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = calc_roots();

  // log2 in Q.24, same squaring recurrence as the datapath
  function automatic logic [LOG_W-1:0] lg_q24(input logic [31:0] v);
    logic [4:0]  n;
    logic [63:0] z;
    logic [LOG_W-1:0] res;
    n = 5'd0;
    for (int j = 0; j < 31; j++) begin
      if ((v >> (j + 1)) != 32'd0) n = 5'(j + 1);
    end
    z = 64'(v) << (31 - n);
    res = LOG_W'(n) << FRAC_BITS;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      z = (z * z) >> 31;
      if (z >= (64'd1 << 32)) begin
        res[i] = 1'b1;
        z = z >> 1;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/rpf_in_if.sv =====
interface rpf_in_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// ===== sv/rpf_out_if.sv =====
interface rpf_out_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== sv/rgb_pixel_filter_gamma_unit.sv =====
// Gamma path: input stage, log cells, exp setup register, exp cells, divide
// cells, result register, output register. Throughput: one pixel per cycle while
// the skid stage is empty; each log, exp and divide cell is one pipeline stage.
// An output register with a one-beat skid stage decouples the two sides.
// Reset (synchronous, rst_n low): mode 0, channel_enable 7,
// gamma_exponent 4096, pipeline and output empty.
module rgb_pixel_filter_gamma_unit import rpf_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rpf_in_if.sink                in_pix,
  rpf_out_if.source             out_pix,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  localparam int CB  = CHANNEL_BITS;
  localparam int QW  = CB + 10;
  localparam int NST = 1 + FRAC_BITS + 1 + FRAC_BITS + QW + 1;
  localparam int SUM_W = CB + 2;
  localparam int DIV_S = CB + 4;
  localparam logic [DIV_S:0] DIV_K = (DIV_S+1)'(((64'd1 << DIV_S) + 64'd2) / 3);

  logic [1:0]         mode_r;
  logic [2:0]         ch_en_r;
  logic [GAMMA_W-1:0] gamma_r;

  logic               en;
  logic [NST-1:0]     v_r;
  logic [CB-1:0]      pix_r [NST][3];
  logic [CB-1:0]      gam [3];
  logic [CB-1:0]      cin [3];
  logic [CB-1:0]      res [3];
  logic [SUM_W-1:0]   sum;
  logic [SUM_W+DIV_S:0] prod;
  logic [CB-1:0]      avg;
  logic               push;

  logic               out_valid_r;
  logic [CB-1:0]      out_r  [3];
  logic               skid_full_r;
  logic [CB-1:0]      skid_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GRAY;
      ch_en_r <= 3'd7;
      gamma_r <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_CH_EN: ch_en_r <= cfg_data[2:0];
        REG_GAMMA: gamma_r <= cfg_data[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  assign en           = !skid_full_r;
  assign in_pix.ready = en;

  assign cin[0] = in_pix.red_in;
  assign cin[1] = in_pix.green_in;
  assign cin[2] = in_pix.blue_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_pix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[0] <= cin;
      for (int s = 1; s < NST; s++) pix_r[s] <= pix_r[s-1];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    rpf_gamma_lane #(.CHANNEL_BITS(CB)) u_lane (
      .clk(clk), .en(en), .x(cin[c]), .g(gamma_r), .y(gam[c])
    );
  end

  always_comb begin
    sum  = SUM_W'(pix_r[NST-1][0]) + SUM_W'(pix_r[NST-1][1]) + SUM_W'(pix_r[NST-1][2]);
    prod = (SUM_W+DIV_S+1)'(sum) * (SUM_W+DIV_S+1)'(DIV_K);
    avg  = prod[DIV_S +: CB];
    for (int c = 0; c < 3; c++) begin
      case (mode_r)
        MODE_GRAY:      res[c] = avg;
        MODE_MASK:      res[c] = ch_en_r[c] ? pix_r[NST-1][c] : '0;
        MODE_THRESHOLD: res[c] = {CB{pix_r[NST-1][c][CB-1]}};
        MODE_GAMMA:     res[c] = gam[c];
        default:        res[c] = gam[c];
      endcase
    end
  end

  assign push = en && v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_pix.ready || !out_valid_r) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pix.ready || !out_valid_r) begin
      if (skid_full_r) out_r <= skid_r;
      else             out_r <= res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = out_r[0];
  assign out_pix.green_out = out_r[1];
  assign out_pix.blue_out  = out_r[2];

endmodule

// ===== sv/rpf_log_cell.sv =====
module rpf_log_cell import rpf_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       en,
  input  log_stage_t d_in,
  output log_stage_t d_out
);

  log_stage_t  st_r;
  log_stage_t  st_nxt;
  logic [63:0] sq;
  logic [32:0] t;

  always_comb begin
    sq     = 64'(d_in.z) * 64'(d_in.z);
    t      = sq[63:31];
    st_nxt = d_in;
    if (t[32]) begin
      st_nxt.z        = t[32:1];
      st_nxt.acc[BIT] = 1'b1;
    end else begin
      st_nxt.z = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

// ===== sv/rpf_exp_cell.sv =====
module rpf_exp_cell import rpf_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       en,
  input  exp_stage_t d_in,
  output exp_stage_t d_out
);

  exp_stage_t  st_r;
  exp_stage_t  st_nxt;
  logic [63:0] prod;

  always_comb begin
    prod   = 64'(d_in.fr) * 64'(ROOT_TAB[IDX]);
    st_nxt = d_in;
    if (d_in.f[FRAC_BITS-1-IDX]) st_nxt.fr = prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

// ===== sv/rpf_div_cell.sv =====
module rpf_div_cell import rpf_pkg::*; #(
  parameter int QW = 18
) (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     r_in,
  input  logic [QW-1:0]   q_in,
  input  div_ctl_t        ctl_in,
  output logic [31:0]     r_out,
  output logic [QW-1:0]   q_out,
  output div_ctl_t        ctl_out
);

  logic [31:0]   r_r, r_nxt;
  logic [QW-1:0] q_r, q_nxt;
  div_ctl_t      ctl_r;
  logic [32:0]   r2;
  logic [32:0]   diff;

  always_comb begin
    r2   = {r_in, 1'b0};
    diff = r2 - {1'b0, ctl_in.fr};
    if (r2 >= {1'b0, ctl_in.fr}) begin
      r_nxt = diff[31:0];
      q_nxt = {q_in[QW-2:0], 1'b1};
    end else begin
      r_nxt = r2[31:0];
      q_nxt = {q_in[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_nxt;
      q_r   <= q_nxt;
      ctl_r <= ctl_in;
    end
  end

  assign r_out   = r_r;
  assign q_out   = q_r;
  assign ctl_out = ctl_r;

endmodule

// ===== sv/rpf_gamma_lane.sv =====
module rpf_gamma_lane import rpf_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [CHANNEL_BITS-1:0] x,
  input  logic [GAMMA_W-1:0]      g,
  output logic [CHANNEL_BITS-1:0] y
);

  localparam int QW = CHANNEL_BITS + 10;
  localparam int OW = QW - 9;
  localparam logic [CHANNEL_BITS-1:0] CH_MAX = {CHANNEL_BITS{1'b1}};
  localparam logic [LOG_W-1:0] LOG_MAX = lg_q24(32'(CH_MAX));
  localparam logic [31:0] R_INIT = 32'(CH_MAX) << (30 - CHANNEL_BITS);

  log_stage_t  lg   [FRAC_BITS+1];
  exp_stage_t  ex   [FRAC_BITS+1];
  logic [31:0]   dr [QW+1];
  logic [QW-1:0] dq [QW+1];
  div_ctl_t      dc [QW+1];

  log_stage_t  s0_r, s0_nxt;
  logic [4:0]  n;
  exp_stage_t  e_r, e_nxt;
  logic [LOG_W-1:0] m;
  logic [44:0] gm;
  logic [32:0] e;
  logic [CHANNEL_BITS-1:0] y_r, y_nxt;
  logic [QW-1:0] sh;
  logic [QW:0]   rnd;
  logic [OW-1:0] o;

  always_comb begin
    n = 5'd0;
    for (int j = 0; j < CHANNEL_BITS; j++) begin
      if (x[j]) n = 5'(j);
    end
    s0_nxt.z    = 32'(x) << (5'd31 - n);
    s0_nxt.acc  = LOG_W'(n) << FRAC_BITS;
    s0_nxt.zero = (x == '0);
  end

  always_ff @(posedge clk) begin
    if (en) s0_r <= s0_nxt;
  end

  assign lg[0] = s0_r;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_log
    rpf_log_cell #(.BIT(FRAC_BITS - 1 - i)) u_cell (
      .clk(clk), .en(en), .d_in(lg[i]), .d_out(lg[i+1])
    );
  end

  always_comb begin
    m  = (LOG_MAX > lg[FRAC_BITS].acc) ? LOG_MAX - lg[FRAC_BITS].acc : '0;
    gm = 45'(g) * 45'(m);
    e  = gm[44:12];
    e_nxt.f    = e[FRAC_BITS-1:0];
    e_nxt.k    = e[32:24];
    e_nxt.fr   = 32'd1 << 30;
    e_nxt.zero = lg[FRAC_BITS].zero;
  end

  always_ff @(posedge clk) begin
    if (en) e_r <= e_nxt;
  end

  assign ex[0] = e_r;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_exp
    rpf_exp_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(en), .d_in(ex[i]), .d_out(ex[i+1])
    );
  end

  assign dr[0] = R_INIT;
  assign dq[0] = '0;
  assign dc[0] = '{fr: ex[FRAC_BITS].fr, k: ex[FRAC_BITS].k, zero: ex[FRAC_BITS].zero};

  for (genvar j = 0; j < QW; j++) begin : g_div
    rpf_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .en(en),
      .r_in(dr[j]), .q_in(dq[j]), .ctl_in(dc[j]),
      .r_out(dr[j+1]), .q_out(dq[j+1]), .ctl_out(dc[j+1])
    );
  end

  always_comb begin
    sh  = dq[QW] >> dc[QW].k;
    rnd = {1'b0, sh} + (QW+1)'(4);
    o   = rnd[QW:10];
    if (o > OW'(CH_MAX)) y_nxt = CH_MAX;
    else                 y_nxt = o[CHANNEL_BITS-1:0];
    if (g == '0)         y_nxt = CH_MAX;
    else if (dc[QW].zero) y_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;

endmodule
